// ===== hdl/stl_pkg.sv =====
// Shared types, character codes and token kinds of the source token lexer.
package stl_pkg;

	localparam int POS_BITS_DEF = 24;
	localparam int FIELD_W      = 24;
	localparam int KIND_W       = 5;
	localparam int TOK_MAX      = 4;
	localparam int CNT_W        = $clog2(TOK_MAX + 1);
	localparam int IDX_W        = $clog2(TOK_MAX);
	localparam int QDEPTH       = 2;

	localparam logic [FIELD_W-1:0] LINE_MAX = '1;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_LB    = 8'h7B;
	localparam logic [7:0] CH_RB    = 8'h7D;

	localparam logic [KIND_W-1:0] K_LPAREN  = 5'd0;
	localparam logic [KIND_W-1:0] K_RPAREN  = 5'd1;
	localparam logic [KIND_W-1:0] K_LBRACE  = 5'd2;
	localparam logic [KIND_W-1:0] K_RBRACE  = 5'd3;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd4;
	localparam logic [KIND_W-1:0] K_COMMA   = 5'd5;
	localparam logic [KIND_W-1:0] K_DOT     = 5'd6;
	localparam logic [KIND_W-1:0] K_MINUS   = 5'd7;
	localparam logic [KIND_W-1:0] K_PLUS    = 5'd8;
	localparam logic [KIND_W-1:0] K_SLASH   = 5'd9;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd10;
	localparam logic [KIND_W-1:0] K_BANG    = 5'd11;
	localparam logic [KIND_W-1:0] K_EQUAL   = 5'd13;
	localparam logic [KIND_W-1:0] K_GREATER = 5'd15;
	localparam logic [KIND_W-1:0] K_LESS    = 5'd17;
	localparam logic [KIND_W-1:0] K_STRING  = 5'd19;
	localparam logic [KIND_W-1:0] K_NUMBER  = 5'd20;
	localparam logic [KIND_W-1:0] K_UNTERM  = 5'd21;
	localparam logic [KIND_W-1:0] K_BADCHAR = 5'd22;
	localparam logic [KIND_W-1:0] K_EOF     = 5'd23;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_source;
	} in_t;

	typedef struct packed {
		logic [KIND_W-1:0]  token_kind;
		logic [FIELD_W-1:0] token_start;
		logic [FIELD_W-1:0] token_length;
		logic [FIELD_W-1:0] token_line;
		logic               run_last;
	} out_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic [FIELD_W-1:0] line;
	} tok_t;

	typedef struct packed {
		logic [CNT_W-1:0]        cnt;
		tok_t [TOK_MAX-1:0]      toks;
	} grp_t;

	function automatic logic [KIND_W-1:0] op_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_BANG: k = K_BANG;
			CH_EQ:   k = K_EQUAL;
			CH_GT:   k = K_GREATER;
			default: k = K_LESS;
		endcase
		return k;
	endfunction

endpackage

// ===== hdl/stl_front.sv =====
// Scanner front end: takes one byte per item and forms the group of tokens it causes.
module stl_front #(
	parameter int POS_BITS = stl_pkg::POS_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  stl_pkg::in_t in_data,
	input  logic         q_full,
	output logic         push,
	output stl_pkg::grp_t push_data
);
	import stl_pkg::*;

	localparam int PB = POS_BITS;
	localparam int EW = (PB + 1 > FIELD_W) ? PB + 1 : FIELD_W;
	localparam logic [PB-1:0] POS_MAX = '1;

	localparam logic [2:0] M_IDLE     = 3'd0;
	localparam logic [2:0] M_OP       = 3'd1;
	localparam logic [2:0] M_SLASH    = 3'd2;
	localparam logic [2:0] M_COMMENT  = 3'd3;
	localparam logic [2:0] M_STRING   = 3'd4;
	localparam logic [2:0] M_NUMBER   = 3'd5;
	localparam logic [2:0] M_NUMDOT   = 3'd6;
	localparam logic [2:0] M_FRACTION = 3'd7;

	logic [2:0]         mode_q;
	logic [7:0]         pend_q;
	logic [PB-1:0]      tb_q;
	logic [PB-1:0]      pos_q;
	logic [FIELD_W-1:0] line_q;

	logic [7:0]         c;
	logic               is_zero;
	logic               is_dig;
	logic               fin;
	logic [PB-1:0]      pos_inc;
	logic [PB-1:0]      dot_pos;
	logic [FIELD_W-1:0] line_inc;
	logic [2:0]         mode_n;
	logic [7:0]         pend_n;
	logic [PB-1:0]      tb_n;
	logic               do_idle;
	logic               inc;
	logic [FIELD_W-1:0] line_a;
	logic [2:0]         mode_f;
	logic [7:0]         pend_f;
	logic [PB-1:0]      tb_f;
	logic [PB-1:0]      pos_f;
	logic [PB-1:0]      dot_f;
	logic [FIELD_W-1:0] line_f;
	tok_t [5:0]         cand;
	logic [5:0]         cv;
	logic [KIND_W-1:0]  pk;
	logic               pk_v;
	grp_t               grp;
	logic [CNT_W-1:0]   n;

	function automatic logic [FIELD_W-1:0] to24(input logic [PB:0] v);
		logic [EW-1:0] e;
		e = EW'(v);
		return e[FIELD_W-1:0];
	endfunction

	function automatic logic [PB:0] span(input logic [PB-1:0] a, input logic [PB-1:0] b);
		logic [PB:0] s;
		s = (b >= a) ? {1'b0, b - a} : '0;
		return s;
	endfunction

	function automatic tok_t mk_tok(input logic [KIND_W-1:0] kind, input logic [PB-1:0] start,
			input logic [PB:0] len, input logic [FIELD_W-1:0] line);
		tok_t t;
		t.kind   = kind;
		t.start  = to24({1'b0, start});
		t.length = to24(len);
		t.line   = line;
		return t;
	endfunction

	assign c        = in_data.text_byte;
	assign is_zero  = (c == 8'd0);
	assign is_dig   = (c >= CH_0) && (c <= CH_9);
	assign fin      = is_zero || in_data.end_of_source;
	assign pos_inc  = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
	assign dot_pos  = (pos_q != '0) ? pos_q - 1'b1 : '0;
	assign line_inc = (line_q == LINE_MAX) ? line_q : line_q + 1'b1;
	assign in_ready = !q_full;

	always_comb begin
		cand    = '0;
		cv      = '0;
		mode_n  = mode_q;
		pend_n  = pend_q;
		tb_n    = tb_q;
		do_idle = 1'b0;
		inc     = 1'b0;
		pk      = K_BADCHAR;
		pk_v    = 1'b0;

		unique case (mode_q)
			M_OP: begin
				mode_n = M_IDLE;
				cv[0]  = 1'b1;
				if (c == CH_EQ) begin
					cand[0] = mk_tok(KIND_W'(op_kind(pend_q) + 5'd1), tb_q, (PB+1)'(2), line_q);
				end else begin
					cand[0] = mk_tok(op_kind(pend_q), tb_q, (PB+1)'(1), line_q);
					do_idle = 1'b1;
				end
			end
			M_SLASH: begin
				if (c == CH_SLASH) begin
					mode_n = M_COMMENT;
				end else begin
					cv[0]   = 1'b1;
					cand[0] = mk_tok(K_SLASH, tb_q, (PB+1)'(1), line_q);
					do_idle = 1'b1;
				end
			end
			M_COMMENT: begin
				if (c == CH_NL) begin
					mode_n = M_IDLE;
					inc    = 1'b1;
				end
			end
			M_STRING: begin
				if (c == CH_QUOTE) begin
					mode_n  = M_IDLE;
					cv[0]   = 1'b1;
					cand[0] = mk_tok(K_STRING, tb_q, span(tb_q, pos_q) + 1'b1, line_q);
				end else if (c == CH_NL) begin
					inc = 1'b1;
				end
			end
			M_NUMBER: begin
				if (c == CH_DOT) begin
					mode_n = M_NUMDOT;
				end else if (!is_dig) begin
					cv[0]   = 1'b1;
					cand[0] = mk_tok(K_NUMBER, tb_q, span(tb_q, pos_q), line_q);
					do_idle = 1'b1;
				end
			end
			M_NUMDOT: begin
				if (is_dig) begin
					mode_n = M_FRACTION;
				end else begin
					cv[1:0] = 2'b11;
					cand[0] = mk_tok(K_NUMBER, tb_q, span(tb_q, dot_pos), line_q);
					cand[1] = mk_tok(K_DOT, dot_pos, (PB+1)'(1), line_q);
					do_idle = 1'b1;
				end
			end
			M_FRACTION: begin
				if (!is_dig) begin
					cv[0]   = 1'b1;
					cand[0] = mk_tok(K_NUMBER, tb_q, span(tb_q, pos_q), line_q);
					do_idle = 1'b1;
				end
			end
			default: begin
				do_idle = 1'b1;
			end
		endcase

		if (do_idle) begin
			mode_n = M_IDLE;
			unique case (c)
				CH_SP, CH_CR, CH_TAB: begin
				end
				CH_NL:    inc = 1'b1;
				CH_LP:    begin pk = K_LPAREN; pk_v = 1'b1; end
				CH_RP:    begin pk = K_RPAREN; pk_v = 1'b1; end
				CH_LB:    begin pk = K_LBRACE; pk_v = 1'b1; end
				CH_RB:    begin pk = K_RBRACE; pk_v = 1'b1; end
				CH_SEMI:  begin pk = K_SEMI;   pk_v = 1'b1; end
				CH_COMMA: begin pk = K_COMMA;  pk_v = 1'b1; end
				CH_DOT:   begin pk = K_DOT;    pk_v = 1'b1; end
				CH_MINUS: begin pk = K_MINUS;  pk_v = 1'b1; end
				CH_PLUS:  begin pk = K_PLUS;   pk_v = 1'b1; end
				CH_STAR:  begin pk = K_STAR;   pk_v = 1'b1; end
				CH_SLASH: begin
					mode_n = M_SLASH;
					tb_n   = pos_q;
				end
				CH_QUOTE: begin
					mode_n = M_STRING;
					tb_n   = pos_q;
				end
				CH_BANG, CH_EQ, CH_GT, CH_LT: begin
					mode_n = M_OP;
					pend_n = c;
					tb_n   = pos_q;
				end
				default: begin
					if (is_dig) begin
						mode_n = M_NUMBER;
						tb_n   = pos_q;
					end else begin
						pk_v = 1'b1;
					end
				end
			endcase
			cv[2]   = pk_v;
			cand[2] = mk_tok(pk, pos_q, (PB+1)'(1), line_q);
		end

		if (is_zero) begin
			cv[2:0] = '0;
		end

		line_a = inc ? line_inc : line_q;
		mode_f = is_zero ? mode_q : mode_n;
		pend_f = is_zero ? pend_q : pend_n;
		tb_f   = is_zero ? tb_q : tb_n;
		pos_f  = is_zero ? pos_q : pos_inc;
		line_f = is_zero ? line_q : line_a;
		dot_f  = (pos_f != '0) ? pos_f - 1'b1 : '0;

		if (fin) begin
			unique case (mode_f)
				M_OP: begin
					cv[3]   = 1'b1;
					cand[3] = mk_tok(op_kind(pend_f), tb_f, (PB+1)'(1), line_f);
				end
				M_SLASH: begin
					cv[3]   = 1'b1;
					cand[3] = mk_tok(K_SLASH, tb_f, (PB+1)'(1), line_f);
				end
				M_STRING: begin
					cv[3]   = 1'b1;
					cand[3] = mk_tok(K_UNTERM, tb_f, span(tb_f, pos_f), line_f);
				end
				M_NUMBER, M_FRACTION: begin
					cv[3]   = 1'b1;
					cand[3] = mk_tok(K_NUMBER, tb_f, span(tb_f, pos_f), line_f);
				end
				M_NUMDOT: begin
					cv[4:3] = 2'b11;
					cand[3] = mk_tok(K_NUMBER, tb_f, span(tb_f, dot_f), line_f);
					cand[4] = mk_tok(K_DOT, dot_f, (PB+1)'(1), line_f);
				end
				default: begin
				end
			endcase
			cv[5]   = 1'b1;
			cand[5] = mk_tok(K_EOF, pos_f, '0, line_f);
		end

		grp = '0;
		n   = '0;
		for (int i = 0; i < 6; i++) begin
			if (cv[i] && (n < CNT_W'(TOK_MAX))) begin
				grp.toks[n[IDX_W-1:0]] = cand[i];
				n = n + 1'b1;
			end
		end
		grp.cnt = n;
	end

	assign push      = in_valid && in_ready && (grp.cnt != '0);
	assign push_data = grp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			pend_q <= '0;
			tb_q   <= '0;
			pos_q  <= '0;
			line_q <= FIELD_W'(1);
		end else if (in_valid && in_ready) begin
			if (fin) begin
				mode_q <= M_IDLE;
				pend_q <= '0;
				tb_q   <= '0;
				pos_q  <= '0;
				line_q <= FIELD_W'(1);
			end else begin
				mode_q <= mode_n;
				pend_q <= pend_n;
				tb_q   <= tb_n;
				pos_q  <= pos_inc;
				line_q <= line_a;
			end
		end
	end

endmodule

// ===== hdl/stl_queue.sv =====
// Short queue of token groups between the scanner and the token sequencer.
module stl_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  stl_pkg::grp_t push_data,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output stl_pkg::grp_t head_data
);
	import stl_pkg::*;

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

	grp_t             ent_q [QDEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W:0]   count_q;

	assign full       = (count_q == (PTR_W+1)'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/stl_back.sv =====
// Token sequencer: sends the tokens of the head group one per item and marks the last.
module stl_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  stl_pkg::grp_t head_data,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_ready,
	output stl_pkg::out_t out_data
);
	import stl_pkg::*;

	logic [IDX_W-1:0] idx_q;
	tok_t             tok;
	logic             last_tok;

	assign tok       = head_data.toks[idx_q];
	assign last_tok  = ((CNT_W'(idx_q) + 1'b1) == head_data.cnt);
	assign out_valid = head_valid;
	assign pop       = out_valid && out_ready && last_tok;

	assign out_data.token_kind   = tok.kind;
	assign out_data.token_start  = tok.start;
	assign out_data.token_length = tok.length;
	assign out_data.token_line   = tok.line;
	assign out_data.run_last     = last_tok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (out_valid && out_ready) begin
			idx_q <= last_tok ? '0 : idx_q + 1'b1;
		end
	end

endmodule

// ===== hdl/source_token_lexer_core.sv =====
// Top level of the source token lexer: byte stream in, token stream out.
// The in channel takes one source byte per item with an end-of-source flag;
// a zero byte or the flag ends the source and produces an EOF token, after
// which positions and the line count start over for the next source.
// The out channel gives one token per item: kind, start offset, length and
// line; run_last is high on the final token caused by one input byte.
// The tokens of an accepted byte are registered in the queue as one group
// and leave from its head. Bytes are taken one per cycle while each byte
// yields at most one token; a byte that yields more holds the out channel
// until each is taken, and the two-group queue between scanner and
// sequencer lets the scanner run ahead until it fills. When the receiver
// stalls, the queue fills and in_ready drops; nothing is lost. Reset clears
// the scanner to idle at offset zero, line one, and empties the queue.
module source_token_lexer_core #(
	parameter int POS_BITS = stl_pkg::POS_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  stl_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output stl_pkg::out_t out_data
);
	import stl_pkg::*;

	logic q_full;
	logic push;
	grp_t push_data;
	logic pop;
	logic head_valid;
	grp_t head_data;

	stl_front #(
		.POS_BITS (POS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	stl_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	stl_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

`ifndef SYNTHESIS
	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.token_kind == K_EOF) |-> out_data.run_last)
		else $error("EOF token is not the last token of its byte.");

	a_eof_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.token_kind == K_EOF) |-> (out_data.token_length == '0))
		else $error("EOF token has a nonzero length.");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.token_line != '0))
		else $error("Token carries line zero.");
`endif

endmodule
